FILE: sv/hrpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrpm_pkg
// Shared types and constants of the HSV red pixel mask: threshold bundle,
// register map and reset values.
// ----------------------------------------------------------------------------
package hrpm_pkg;

    // Threshold registers as seen by the datapath
    typedef struct packed {
        logic [7:0] hue_low;
        logic [7:0] hue_high;
        logic [7:0] sat;
        logic [7:0] value;
    } hrpm_limits_t;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_HUE_LOW  = 2'd0;
    localparam logic [1:0] REG_HUE_HIGH = 2'd1;
    localparam logic [1:0] REG_SAT      = 2'd2;
    localparam logic [1:0] REG_VALUE    = 2'd3;

    localparam int unsigned ADDR_W = 4;

    // Reset values of the thresholds
    localparam logic [7:0] HUE_LOW_RST  = 8'd5;
    localparam logic [7:0] HUE_HIGH_RST = 8'd174;
    localparam logic [7:0] SAT_RST      = 8'd153;
    localparam logic [7:0] VALUE_RST    = 8'd102;

endpackage

FILE: sv/hsv_red_pixel_mask_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_red_pixel_mask_top
// Marks BGR pixels whose HSV colour lies in the red hue band with enough
// saturation and brightness; thresholds sit behind an APB register port.
// ----------------------------------------------------------------------------
// start passes pipe stages A to D before the done strobe carrying marked.
// Throughput: one item per clock; busy is never raised, the four register
//   stages of hrpm_pipe each take a new item every cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset: rst_n clears all valid bits and loads the thresholds with
//   hue low 5, hue high 174, saturation 153, value 102.
// ----------------------------------------------------------------------------
module hsv_red_pixel_mask_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    // pixel command channel
    input  logic                         start,
    output logic                         busy,
    input  logic [7:0]                   blue,
    input  logic [7:0]                   green,
    input  logic [7:0]                   red,
    // result
    output logic                         done,
    output logic                         marked,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hrpm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // Threshold registers
    logic [7:0]             hue_low_reg;
    logic [7:0]             hue_high_reg;
    logic [7:0]             sat_reg;
    logic [7:0]             value_reg;
    logic                   cfg_write;
    logic [1:0]             cfg_index;
    hrpm_pkg::hrpm_limits_t limits;

    // The pipeline never backs up, so every start is taken
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Register index from the word address; low byte bits ignored
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Hold thresholds; load the addressed one on a completed write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg  <= hrpm_pkg::HUE_LOW_RST;
            hue_high_reg <= hrpm_pkg::HUE_HIGH_RST;
            sat_reg      <= hrpm_pkg::SAT_RST;
            value_reg    <= hrpm_pkg::VALUE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hrpm_pkg::REG_HUE_LOW:  hue_low_reg  <= pwdata[7:0];
                hrpm_pkg::REG_HUE_HIGH: hue_high_reg <= pwdata[7:0];
                hrpm_pkg::REG_SAT:      sat_reg      <= pwdata[7:0];
                hrpm_pkg::REG_VALUE:    value_reg    <= pwdata[7:0];
                default:                ;
            endcase
        end
    end

    // Read back the addressed threshold, zero extended
    always_comb
    begin
        case (cfg_index)
            hrpm_pkg::REG_HUE_LOW:  prdata = {24'd0, hue_low_reg};
            hrpm_pkg::REG_HUE_HIGH: prdata = {24'd0, hue_high_reg};
            hrpm_pkg::REG_SAT:      prdata = {24'd0, sat_reg};
            hrpm_pkg::REG_VALUE:    prdata = {24'd0, value_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // Bundle the thresholds for the datapath
    assign limits.hue_low  = hue_low_reg;
    assign limits.hue_high = hue_high_reg;
    assign limits.sat      = sat_reg;
    assign limits.value    = value_reg;

    // Datapath: advance one stage per clock, valid bit alongside each item
    hrpm_pipe u_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .limits    (limits),
        .out_valid (done),
        .marked    (marked)
    );

`ifndef ASSERT_OFF
    // every accepted item yields its result at the end of the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted item produced no result");

    // no result without a matching accepted item at the pipe input
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without accepted item");
`endif

endmodule

FILE: sv/hrpm_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrpm_pipe
// Four-stage datapath: channel max/min and sector, scaled hue numerator and
// saturation products, hue bounds with saturation and value tests, hue test and mark.
// The divisions of the HSV formulas are folded into cross-multiplied compares.
// ----------------------------------------------------------------------------
module hrpm_pipe
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           blue,
    input  logic [7:0]           green,
    input  logic [7:0]           red,
    input  hrpm_pkg::hrpm_limits_t limits,
    output logic                 out_valid,
    output logic                 marked
);

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    // ---------------- stage A: max, min, sector ----------------
    logic              a_valid_reg;
    logic [7:0]        a_vmax_reg, a_vmax_next;
    logic [7:0]        a_diff_reg, a_diff_next;
    logic [1:0]        a_sec_reg,  a_sec_next;
    logic signed [8:0] a_num_reg,  a_num_next;
    logic [7:0]        a_vmin;

    always_comb
    begin
        a_vmax_next = blue;
        a_vmin      = blue;
        if (green > a_vmax_next) a_vmax_next = green;
        if (red   > a_vmax_next) a_vmax_next = red;
        if (green < a_vmin)      a_vmin      = green;
        if (red   < a_vmin)      a_vmin      = red;
        a_diff_next = a_vmax_next - a_vmin;
        // red wins ties, then green
        if (red == a_vmax_next)
        begin
            a_sec_next = SEC_RED;
            a_num_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green == a_vmax_next)
        begin
            a_sec_next = SEC_GREEN;
            a_num_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            a_sec_next = SEC_BLUE;
            a_num_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        a_vmax_reg <= a_vmax_next;
        a_diff_reg <= a_diff_next;
        a_sec_reg  <= a_sec_next;
        a_num_reg  <= a_num_next;
    end

    // ---------------- stage B: hue numerator, saturation products ----------------
    logic               b_valid_reg;
    logic [7:0]         b_vmax_reg, b_diff_reg;
    logic [16:0]        b_n_reg,    b_n_next;
    logic [16:0]        b_sprod_reg, b_sprod_next;
    logic [16:0]        b_slhs_reg,  b_slhs_next;
    logic [16:0]        b_lprod_reg, b_lprod_next;
    logic signed [17:0] b_base;
    logic signed [17:0] b_n_raw;
    logic [17:0]        b_diff_ext;

    always_comb
    begin
        b_diff_ext = {10'd0, a_diff_reg};
        case (a_sec_reg)
            SEC_RED:   b_base = 18'sd0;
            SEC_GREEN: b_base = $signed(b_diff_ext * 18'd60);
            SEC_BLUE:  b_base = $signed(b_diff_ext * 18'd120);
            default:   b_base = 18'sd0;
        endcase
        // half-degree hue times diff
        b_n_raw = b_base + ($signed({{9{a_num_reg[8]}}, a_num_reg}) * 18'sd30);
        if (b_n_raw < 0)
            b_n_raw = b_n_raw + $signed(b_diff_ext * 18'd180);
        b_n_next     = b_n_raw[16:0];
        b_sprod_next = {({8'd0, a_vmax_reg} * {8'd0, limits.sat}), 1'b0};
        b_slhs_next  = 17'({9'd0, a_diff_reg} * 17'd510) + {9'd0, a_vmax_reg};
        b_lprod_next = {9'd0, a_diff_reg} * ({9'd0, limits.hue_low} + 17'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_vmax_reg  <= a_vmax_reg;
        b_diff_reg  <= a_diff_reg;
        b_n_reg     <= b_n_next;
        b_sprod_reg <= b_sprod_next;
        b_slhs_reg  <= b_slhs_next;
        b_lprod_reg <= b_lprod_next;
    end

    // ---------------- stage C: hue bounds, saturation and value tests ----------------
    logic        c_valid_reg;
    logic [17:0] c_x_reg,    c_x_next;
    logic [17:0] c_low_reg,  c_low_next;
    logic [17:0] c_high_reg, c_high_next;
    logic [17:0] c_wrap_reg, c_wrap_next;
    logic        c_grey_reg, c_sat_ok_reg, c_v_ok_reg;
    logic        c_sat_ok_next;

    always_comb
    begin
        c_x_next    = {b_n_reg, 1'b0} + {10'd0, b_diff_reg};
        c_low_next  = {b_lprod_reg, 1'b0};
        c_high_next = {1'b0, ({9'd0, b_diff_reg} * {9'd0, limits.hue_high})} << 1;
        c_wrap_next = {10'd0, b_diff_reg} * 18'd360;
        // a black pixel has zero saturation
        if (b_vmax_reg == 8'd0)
            c_sat_ok_next = (limits.sat == 8'd0);
        else
            c_sat_ok_next = (b_slhs_reg >= b_sprod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        c_x_reg      <= c_x_next;
        c_low_reg    <= c_low_next;
        c_high_reg   <= c_high_next;
        c_wrap_reg   <= c_wrap_next;
        c_grey_reg   <= (b_diff_reg == 8'd0);
        c_sat_ok_reg <= c_sat_ok_next;
        c_v_ok_reg   <= (b_vmax_reg >= limits.value);
    end

    // ---------------- stage D: hue test and mark ----------------
    logic d_valid_reg;
    logic d_mark_reg, d_mark_next;
    logic d_hue_ok;

    always_comb
    begin
        // grey pixels and hue rounded up to 180 both give hue 0
        d_hue_ok = c_grey_reg
                 || (c_x_reg >= c_wrap_reg)
                 || (c_x_reg <  c_low_reg)
                 || (c_x_reg >= c_high_reg);
        d_mark_next = d_hue_ok && c_sat_ok_reg && c_v_ok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        d_mark_reg <= d_mark_next;
    end

    assign out_valid = d_valid_reg;
    assign marked    = d_mark_reg;

`ifndef ASSERT_OFF
    // black pixel can only pass saturation with a zero limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && $past(b_vmax_reg) == 8'd0 && $past(limits.sat) != 8'd0)
        |-> !c_sat_ok_reg)
        else $error("black pixel passed saturation test");

    // a mark requires the value test to have passed
    assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && d_mark_reg) |-> $past(c_v_ok_reg))
        else $error("mark without value test");
`endif

endmodule
